/* rtl/core/y2p_pkg.sv */
// ----------------------------------------------------------------------------
// y2p_pkg
// Shared types and codes for the YUYV to planar converter.
// ----------------------------------------------------------------------------
package y2p_pkg;

  localparam int unsigned CountW = 11;  // row and column counter width
  localparam int unsigned SizeW  = 12;  // width / height register width
  localparam int unsigned CountLimit = 2048;

  // capture modes
  localparam logic [1:0] MODE_GREY   = 2'd0;
  localparam logic [1:0] MODE_YUV422 = 2'd1;
  localparam logic [1:0] MODE_DROP   = 2'd2;
  localparam logic [1:0] MODE_AVG    = 2'd3;

  // register indexes (byte address / 4)
  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  // how the chroma pair of a word is reported
  typedef enum logic [1:0] {
    CK_NONE,
    CK_PASS,
    CK_AVG
  } chroma_kind_e;

  // position of one capture word in the frame
  typedef struct packed {
    logic [CountW-1:0] row;
    logic [CountW-1:0] col;
    logic              frame_end;
  } pos_t;

endpackage

/* rtl/core/y2p_ram.sv */
// ----------------------------------------------------------------------------
// y2p_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module y2p_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/y2p_pos.sv */
// ----------------------------------------------------------------------------
// y2p_pos
// Column and row counters; flags line and frame ends.
// ----------------------------------------------------------------------------
module y2p_pos #(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned MAX_HEIGHT = 2048
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       acc_i,
  input  logic [1:0]                 mode_i,
  input  logic [y2p_pkg::SizeW-1:0]  line_width_i,
  input  logic [y2p_pkg::SizeW-1:0]  frame_height_i,
  output y2p_pkg::pos_t              pos_o
);
  import y2p_pkg::*;

  localparam int unsigned ClampW = (MAX_WIDTH < CountLimit) ? MAX_WIDTH : CountLimit;
  localparam int unsigned ClampH = (MAX_HEIGHT < CountLimit) ? MAX_HEIGHT : CountLimit;

  logic [CountW-1:0] col_q, col_d;
  logic [CountW-1:0] row_q, row_d;
  logic [SizeW-1:0]  w_eff, h_eff;
  logic [SizeW-1:0]  col_sum, row_sum;
  logic [2:0]        step;
  logic              line_end, last_row;

  assign w_eff = (line_width_i > SizeW'(ClampW)) ? SizeW'(ClampW) : line_width_i;
  assign h_eff = (frame_height_i > SizeW'(ClampH)) ? SizeW'(ClampH) : frame_height_i;

  assign step     = (mode_i == MODE_GREY) ? 3'd4 : 3'd2;
  assign col_sum  = {1'b0, col_q} + SizeW'(step);
  assign row_sum  = {1'b0, row_q} + SizeW'(1);
  assign line_end = col_sum >= w_eff;
  assign last_row = row_sum >= h_eff;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (acc_i) begin
      if (line_end) begin
        col_d = '0;
        row_d = last_row ? '0 : row_sum[CountW-1:0];
      end else begin
        col_d = col_sum[CountW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign pos_o.row       = row_q;
  assign pos_o.col       = col_q;
  assign pos_o.frame_end = line_end && last_row;

endmodule

/* rtl/core/y2p_chroma.sv */
// ----------------------------------------------------------------------------
// y2p_chroma
// Chroma path: pass/drop by mode; AVG buffers even lines, averages odd lines.
// ----------------------------------------------------------------------------
module y2p_chroma #(
  parameter int unsigned LINE_DEPTH = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        acc_i,
  input  logic [1:0]                  mode_i,
  input  logic                        odd_i,
  input  logic [y2p_pkg::CountW-1:0]  col_i,
  input  logic [7:0]                  u_i,
  input  logic [7:0]                  v_i,
  output logic [7:0]                  u_o,
  output logic [7:0]                  v_o,
  output logic                        valid_o
);
  import y2p_pkg::*;

  localparam int unsigned AW = $clog2(LINE_DEPTH);
  localparam int unsigned IW = (AW > CountW - 1) ? AW + 1 : CountW;

  logic [IW-1:0]  idx_full, idx_wrap;
  logic [AW-1:0]  addr;
  logic           we, re;
  logic [15:0]    rdata;
  chroma_kind_e   kind_d, kind_q;
  logic [7:0]     u_q, v_q;
  logic [8:0]     u_sum, v_sum;

  // col/2 folded into the buffer depth; col/2 never reaches twice the depth
  assign idx_full = IW'(col_i[CountW-1:1]);
  assign idx_wrap = (idx_full >= IW'(LINE_DEPTH)) ? idx_full - IW'(LINE_DEPTH) : idx_full;
  assign addr     = idx_wrap[AW-1:0];

  assign we = acc_i && (mode_i == MODE_AVG) && !odd_i;
  assign re = acc_i && (mode_i == MODE_AVG) && odd_i;

  y2p_ram #(
    .WIDTH (16),
    .DEPTH (LINE_DEPTH)
  ) u_line_buf (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (addr),
    .wdata_i ({v_i, u_i}),
    .re_i    (re),
    .raddr_i (addr),
    .rdata_o (rdata)
  );

  always_comb begin
    unique case (mode_i)
      MODE_GREY:   kind_d = CK_NONE;
      MODE_YUV422: kind_d = CK_PASS;
      MODE_DROP:   kind_d = odd_i ? CK_NONE : CK_PASS;
      MODE_AVG:    kind_d = odd_i ? CK_AVG : CK_NONE;
      default:     kind_d = CK_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= CK_NONE;
    end else if (acc_i) begin
      kind_q <= kind_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      u_q <= u_i;
      v_q <= v_i;
    end
  end

  assign u_sum = {1'b0, rdata[7:0]} + {1'b0, u_q};
  assign v_sum = {1'b0, rdata[15:8]} + {1'b0, v_q};

  always_comb begin
    case (kind_q)
      CK_PASS: begin
        u_o = u_q;
        v_o = v_q;
        valid_o = 1'b1;
      end
      CK_AVG: begin
        u_o = u_sum[8:1];
        v_o = v_sum[8:1];
        valid_o = 1'b1;
      end
      default: begin
        u_o = '0;
        v_o = '0;
        valid_o = 1'b0;
      end
    endcase
  end

endmodule

/* rtl/core/yuyv_to_planar_420_converter.sv */
// ----------------------------------------------------------------------------
// yuyv_to_planar_420_converter
// Splits packed YUYV / greyscale capture words into luma and chroma samples.
// ----------------------------------------------------------------------------
// Input stream: one 4-byte capture word per transaction (Y0 U Y1 V, or four
// grey samples). Output stream: one transaction per input word, carrying up
// to four luma samples, an optional chroma pair (tuser high when present),
// the luma row and column of the first sample, and tlast on the last word of
// the frame.
// Pipeline: an input word is held in the middle stage and then in the output
// register, which drives tvalid.
// Throughput: one word per clock while the output is ready; the line buffer is
// a one-port-write, one-port-read RAM, written or read at most once per word.
// 4:2:0 averaged mode stores even-line chroma at column/2 and averages it
// (floor) with the odd-line pair of the same column on the next line.
// Configuration: APB registers mode (0x0), line_width (0x4), frame_height
// (0x8). Reset gives mode 2 (4:2:0 drop), 384 x 288, and clears row and
// column. The line buffer is not cleared; odd lines must follow even lines.
// Stall: with the output held off, one word waits in the output register and
// one in the middle stage; tready drops only once both are full.
// ----------------------------------------------------------------------------
module yuyv_to_planar_420_converter #(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned MAX_HEIGHT = 2048
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // byte0, byte1, byte2, byte3
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,  // luma0..3, chroma_u, chroma_v, row, col, pad
  output logic        m_axis_tuser,  // chroma_valid
  output logic        m_axis_tlast   // frame_end
);
  import y2p_pkg::*;

  localparam int unsigned LineDepth = MAX_WIDTH / 2;

  // ---- configuration registers ----
  logic [1:0]       mode_q;
  logic [SizeW-1:0] line_width_q, frame_height_q;
  logic             cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q         <= MODE_DROP;
      line_width_q   <= SizeW'(384);
      frame_height_q <= SizeW'(288);
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        REG_MODE:   mode_q         <= pwdata[1:0];
        REG_WIDTH:  line_width_q   <= pwdata[SizeW-1:0];
        REG_HEIGHT: frame_height_q <= pwdata[SizeW-1:0];
        default:    ;  // unmapped register, write dropped
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_MODE:   prdata = {30'd0, mode_q};
      REG_WIDTH:  prdata = {20'd0, line_width_q};
      REG_HEIGHT: prdata = {20'd0, frame_height_q};
      default:    prdata = '0;
    endcase
  end

  // ---- handshake and stage control ----
  logic s1_valid_q, s1_valid_d;
  logic out_valid_q, out_valid_d;
  logic adv, acc;

  // middle stage moves on when the output register is free or being drained
  assign adv           = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || adv;
  assign acc           = s_axis_tvalid && s_axis_tready;

  assign s1_valid_d  = acc ? 1'b1 : (adv ? 1'b0 : s1_valid_q);
  assign out_valid_d = adv ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // ---- position counters ----
  pos_t pos;

  y2p_pos #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_pos (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .acc_i          (acc),
    .mode_i         (mode_q),
    .line_width_i   (line_width_q),
    .frame_height_i (frame_height_q),
    .pos_o          (pos)
  );

  // ---- chroma path (line buffer sits in here) ----
  logic [7:0] cu, cv;
  logic       cvalid;

  y2p_chroma #(
    .LINE_DEPTH (LineDepth)
  ) u_chroma (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .acc_i   (acc),
    .mode_i  (mode_q),
    .odd_i   (pos.row[0]),
    .col_i   (pos.col),
    .u_i     (s_axis_tdata[15:8]),
    .v_i     (s_axis_tdata[31:24]),
    .u_o     (cu),
    .v_o     (cv),
    .valid_o (cvalid)
  );

  // ---- luma and position, middle stage ----
  logic [31:0] luma_d, luma_q;
  pos_t        pos_q;

  // greyscale: four samples straight through; YUYV: Y0 and Y1 only
  assign luma_d = (mode_q == MODE_GREY) ? s_axis_tdata
                                        : {16'd0, s_axis_tdata[23:16], s_axis_tdata[7:0]};

  always_ff @(posedge clk_i) begin
    if (acc) begin
      luma_q <= luma_d;
      pos_q  <= pos;
    end
  end

  // ---- output register ----
  logic [71:0] odata_q;
  logic        ouser_q, olast_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      odata_q <= {2'b00, pos_q.col, pos_q.row, cv, cu, luma_q};
      ouser_q <= cvalid;
      olast_q <= pos_q.frame_end;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tuser  = ouser_q;
  assign m_axis_tlast  = olast_q;

  // ---- assertions ----
  // input back-pressure only comes from a full middle stage and output register
  a_ready_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> s1_valid_q && out_valid_q)
    else $error("input stalled with room in the pipeline");

  // chroma is never reported alongside greyscale samples
  a_chroma_not_grey: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[31:16] == 16'd0)
    else $error("chroma emitted with greyscale luma");

  // columns step by two or four from zero, so always even
  a_col_even: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !m_axis_tdata[59])
    else $error("odd column reported");

  // a word accepted into a free pipeline reaches the output register next
  a_no_loss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !out_valid_q |=> out_valid_q)
    else $error("middle stage failed to drain");

endmodule
